// ===== sv/ksat_parallel_resampler_assert.svh =====
// ============================================================================
// Assertion macros for the k-SAT resampler
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ============================================================================
`ifndef KSAT_PARALLEL_RESAMPLER_ASSERT_SVH
`define KSAT_PARALLEL_RESAMPLER_ASSERT_SVH

// Same-cycle implication.
`define KPR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("resampler assertion failed");

// Next-cycle implication.
`define KPR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("resampler assertion failed");

`endif

// ===== sv/kpr_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// kpr_pkg
// Shared constants for the k-SAT resampler.
// ============================================================================
package kpr_pkg;
  localparam int LITERALS_DEF      = 3;
  localparam int NUM_VARIABLES_DEF = 1024;
  localparam int CARRIED_LITS      = 3;
  localparam int IDX_W             = 10;
  localparam int CNT_W             = 16;

  localparam logic [1:0] OP_CHECK = 2'd0;
  localparam logic [1:0] OP_END   = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;
endpackage

// ===== sv/kpr_ram.sv =====
`timescale 1ns / 1ps
// ============================================================================
// kpr_ram
// Simple dual-port RAM, one write port and one registered read port.
// ============================================================================
module kpr_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/ksat_parallel_resampler.sv =====
`timescale 1ns / 1ps
// A check examines the literals one by one and, if none is satisfied, resamples each in
// turn; an end of round copies the assignment into the snapshot (sweep, one entry a cycle).
// Throughput: one item at a time; the next beat is taken once the result has
// left or is leaving the output register. Set by the single read port per RAM.
// Reset: synchronous, active low; then a clearing pass zeroes both RAMs,
// during which no beat is accepted.
// ============================================================================
// ksat_parallel_resampler
// Parallel resampling k-SAT core: live assignment and round snapshot in RAM.
// ============================================================================
module ksat_parallel_resampler #(
  parameter int LITERALS      = kpr_pkg::LITERALS_DEF,
  parameter int NUM_VARIABLES = kpr_pkg::NUM_VARIABLES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // var_index_a[9:0], var_index_b[19:10], var_index_c[29:20], sat_value_a[30],
  // sat_value_b[31], sat_value_c[32], random_bits[35:33], zero fill [39:36]
  input  logic [39:0] in_tdata,
  // op[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // clause_bad[0], round_bad[1], read_bit[2], round_count[18:3], zero fill [23:19]
  output logic [23:0] out_tdata
);
  localparam int AW   = $clog2(NUM_VARIABLES);
  localparam int NLIT = (LITERALS < kpr_pkg::CARRIED_LITS) ? LITERALS : kpr_pkg::CARRIED_LITS;
  localparam int KW   = 2;

  // Sequencer state codes.
  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EV   = 3'd3;
  localparam logic [2:0] S_RS   = 3'd4;
  localparam logic [2:0] S_CPY  = 3'd5;
  localparam logic [2:0] S_WR   = 3'd6;
  localparam logic [2:0] S_RV   = 3'd7;

  logic [2:0]  state_r, state_nxt;
  logic [AW:0] cnt_r, cnt_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic        viol_r, viol_nxt;
  logic [kpr_pkg::CNT_W-1:0] rounds_r, rounds_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [23:0] out_data_r, out_data_nxt;
  logic        pend_r, pend_nxt;
  logic [AW-1:0] pend_addr_r, pend_addr_nxt;

  // Latched item fields.
  logic [kpr_pkg::IDX_W-1:0] idx_r [kpr_pkg::CARRIED_LITS];
  logic [kpr_pkg::CARRIED_LITS-1:0] want_r, rnd_r;

  logic          accept;
  logic [kpr_pkg::CARRIED_LITS-1:0] in_rng;
  logic [AW-1:0] lit_addr [kpr_pkg::CARRIED_LITS];
  logic          asg_we, snp_we, asg_wd, snp_wd, asg_rd, snp_rd;
  logic [AW-1:0] asg_wa, snp_wa, asg_ra, snp_ra;
  logic          snap_bit, hit;
  logic [kpr_pkg::CNT_W-1:0] rounds_inc;

  assign accept     = in_tvalid && in_tready;
  assign in_tready  = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    for (int i = 0; i < kpr_pkg::CARRIED_LITS; i++) begin
      in_rng[i]   = (32'(idx_r[i]) < NUM_VARIABLES);
      lit_addr[i] = AW'(idx_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r[0] <= in_tdata[9:0];
      idx_r[1] <= in_tdata[19:10];
      idx_r[2] <= in_tdata[29:20];
      want_r   <= in_tdata[32:30];
      rnd_r    <= in_tdata[35:33];
    end
  end

  // Out-of-range variables read as zero.
  assign snap_bit   = in_rng[k_r] ? snp_rd : 1'b0;
  assign hit        = (snap_bit == want_r[k_r]);
  assign rounds_inc = (viol_r && (rounds_r != {kpr_pkg::CNT_W{1'b1}})) ?
                      rounds_r + 1'b1 : rounds_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    viol_nxt      = viol_r;
    rounds_nxt    = rounds_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = cnt_r[AW-1:0];
    asg_we = 1'b0; asg_wa = lit_addr[0]; asg_wd = 1'b0;
    snp_we = 1'b0; snp_wa = lit_addr[0]; snp_wd = 1'b0;
    asg_ra = (state_r == S_CPY) ? cnt_r[AW-1:0] : lit_addr[0];
    snp_ra = lit_addr[k_r];
    // The snapshot copy writes in the cycle after its read.
    if (pend_r) begin
      snp_we = 1'b1;
      snp_wa = pend_addr_r;
      snp_wd = asg_rd;
    end
    case (state_r)
      S_CLR: begin
        asg_we = 1'b1; asg_wa = cnt_r[AW-1:0];
        snp_we = 1'b1; snp_wa = cnt_r[AW-1:0];
        cnt_nxt = cnt_r + 1'b1;
        if (32'(cnt_r) == NUM_VARIABLES - 1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        cnt_nxt = '0;
        k_nxt   = '0;
        if (accept) begin
          case (in_tuser)
            kpr_pkg::OP_CHECK: state_nxt = S_RD;
            kpr_pkg::OP_END:   state_nxt = S_CPY;
            kpr_pkg::OP_WRITE: state_nxt = S_WR;
            default:           state_nxt = S_RV;
          endcase
        end
      end
      S_RD: begin
        state_nxt = S_EV;
      end
      S_EV: begin
        if (hit) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'b0, rounds_r, 3'b000};
          state_nxt     = S_IDLE;
        end else if (32'(k_r) == NLIT - 1) begin
          k_nxt     = '0;
          state_nxt = S_RS;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RS: begin
        // Literals are written in order, so a repeated variable keeps the last.
        asg_we = in_rng[k_r];
        asg_wa = lit_addr[k_r];
        asg_wd = rnd_r[k_r];
        if (32'(k_r) == NLIT - 1) begin
          viol_nxt      = 1'b1;
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'b0, rounds_r, 3'b001};
          state_nxt     = S_IDLE;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_CPY: begin
        if (32'(cnt_r) < NUM_VARIABLES) begin
          pend_nxt = 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
        end else begin
          rounds_nxt    = rounds_inc;
          viol_nxt      = 1'b0;
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'b0, rounds_inc, 1'b0, viol_r, 1'b0};
          state_nxt     = S_IDLE;
        end
      end
      S_WR: begin
        asg_we = in_rng[0]; asg_wd = want_r[0];
        snp_we = in_rng[0]; snp_wd = want_r[0];
        out_valid_nxt = 1'b1;
        out_data_nxt  = {5'b0, rounds_r, 3'b000};
        state_nxt     = S_IDLE;
      end
      S_RV: begin
        // Holds the read address while the registered read data arrives.
        if (k_r == '0) begin
          k_nxt = k_r + 1'b1;
        end else begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'b0, rounds_r, (in_rng[0] & asg_rd), 2'b00};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      cnt_r       <= '0;
      k_r         <= '0;
      viol_r      <= 1'b0;
      rounds_r    <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      viol_r      <= viol_nxt;
      rounds_r    <= rounds_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    pend_addr_r <= pend_addr_nxt;
  end

  kpr_ram #(.WIDTH(1), .DEPTH(NUM_VARIABLES)) u_assign_ram (
    .clk(clk), .we(asg_we), .waddr(asg_wa), .wdata(asg_wd), .raddr(asg_ra), .rdata(asg_rd)
  );

  kpr_ram #(.WIDTH(1), .DEPTH(NUM_VARIABLES)) u_snap_ram (
    .clk(clk), .we(snp_we), .waddr(snp_wa), .wdata(snp_wd), .raddr(snp_ra), .rdata(snp_rd)
  );

`include "ksat_parallel_resampler_assert.svh"

  // An accepted beat always leaves the idle state for its work.
  `KPR_ASSERT_NXT(a_busy_after_accept, accept, state_r != S_IDLE)
  // The round counter never decreases.
  `KPR_ASSERT_NXT(a_rounds_monotonic, 1'b1, rounds_r >= $past(rounds_r))
  // A reported violated clause leaves the round flag set.
  `KPR_ASSERT_IMP(a_bad_sets_flag, out_valid_r && out_data_r[0], viol_r)
  // No beat is taken during the clearing pass.
  `KPR_ASSERT_IMP(a_no_accept_clear, state_r == S_CLR, !in_tready)
endmodule
